/* rtl/rsfd_pkg.sv */
package rsfd_pkg;

  localparam int FRAME_BYTES = 33;
  localparam int LAST_IDX    = FRAME_BYTES - 1;
  localparam int CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] HDR_BYTE = 8'hFE;

  // Only payload bytes 0..17 and 26..31 are ever read back.
  localparam int LO_BYTES = 18;
  localparam int HI_FIRST = 26;
  localparam int HI_END   = 32;
  localparam int SLOTS    = LO_BYTES + (HI_END - HI_FIRST);
  localparam int SLOT_W   = $clog2(SLOTS);

  localparam int STALL_BYTE = 4;

  // Slot positions of the bytes read at fixed places
  localparam int SL_BKP_FLAG = 15;
  localparam int SL_BATT     = 16;
  localparam int SL_BKP      = 17;
  localparam int SL_YAW      = HI_FIRST + 4 - (HI_FIRST - LO_BYTES);

  localparam logic [3:0] BKP_TAG = 4'h3;
  localparam logic [31:0] LE16_OFFSET = 32'd10000;

  // Result quantity codes
  localparam logic [3:0] Q_VEL0  = 4'd0;
  localparam logic [3:0] Q_VEL2  = 4'd2;
  localparam logic [3:0] Q_ACC0  = 4'd3;
  localparam logic [3:0] Q_GYR2  = 4'd8;
  localparam logic [3:0] Q_BATT  = 4'd9;
  localparam logic [3:0] Q_BKP   = 4'd10;
  localparam logic [3:0] Q_ROLL  = 4'd11;
  localparam logic [3:0] Q_YAW   = 4'd13;
  localparam logic [3:0] Q_TOTAL = 4'd14;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_STALL = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    status_t                       kind;
    logic [3:0]                    mask;
    logic [SLOTS-1:0][7:0]         bytes;
  } frame_rec_t;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/rsfd_front.sv */
module rsfd_front import rsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  q_status_t  qs,
  output logic       hold,
  output logic       push,
  output frame_rec_t rec
);

  typedef enum logic [2:0] {
    PH_SEEK1 = 3'b001,
    PH_SEEK2 = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  phase_t                phase, phase_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [7:0]            csum;
  logic [9:0]            s4;
  logic [3:0]            mask;
  logic                  stall_hit;
  logic [SLOTS-1:0][7:0] cap;
  logic                  at_last, body_take, slot_we;
  logic [SLOT_W-1:0]     slot_idx;

  assign at_last   = (phase == PH_BODY) && (count == CNT_W'(LAST_IDX));
  // hold the last byte of a frame until the queue has room
  assign hold      = at_last && qs.full;
  assign body_take = take && (phase == PH_BODY);
  assign push      = body_take && at_last;

  always_comb begin
    phase_next = phase;
    count_next = count;
    if (take) begin
      unique case (phase)
        PH_SEEK2: begin
          phase_next = (rx_byte == HDR_BYTE) ? PH_BODY : PH_SEEK1;
          count_next = '0;
        end
        PH_BODY: begin
          if (at_last) begin
            phase_next = PH_SEEK1;
            count_next = '0;
          end else begin
            count_next = count + 1'b1;
          end
        end
        default: begin
          if (rx_byte == HDR_BYTE) phase_next = PH_SEEK2;
        end
      endcase
    end
  end

  always_comb begin
    slot_we  = 1'b0;
    slot_idx = '0;
    if (count < CNT_W'(LO_BYTES)) begin
      slot_we  = 1'b1;
      slot_idx = SLOT_W'(count);
    end else if (count >= CNT_W'(HI_FIRST) && count < CNT_W'(HI_END)) begin
      slot_we  = 1'b1;
      slot_idx = SLOT_W'(count - CNT_W'(HI_FIRST - LO_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK1;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
    if (body_take) begin
      if (count == '0) begin
        csum <= rx_byte;
        s4   <= {2'b00, rx_byte};
      end else if (!at_last) begin
        csum <= csum + rx_byte;
        if (count < CNT_W'(STALL_BYTE)) s4 <= s4 + {2'b00, rx_byte};
      end
      if (count < CNT_W'(STALL_BYTE)) mask[count[1:0]] <= (rx_byte == 8'd1);
      if (count == CNT_W'(STALL_BYTE)) stall_hit <= (s4 == {2'b00, rx_byte});
      if (slot_we) cap[slot_idx] <= rx_byte;
    end
  end

  always_comb begin
    rec.bytes = cap;
    rec.mask  = mask;
    if (stall_hit) rec.kind = ST_STALL;
    else if (csum == rx_byte) rec.kind = ST_GOOD;
    else rec.kind = ST_ERR;
  end

endmodule

/* rtl/rsfd_queue.sv */
module rsfd_queue import rsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t wr_rec,
  input  logic       pop,
  output frame_rec_t head,
  output q_status_t  qs
);

  frame_rec_t        mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push, do_pop;

  assign qs.full  = (fill == QCNT_W'(Q_DEPTH));
  assign qs.empty = (fill == '0);
  assign do_push  = push && !qs.full;
  assign do_pop   = pop && !qs.empty;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
    if (do_push) mem[wr_ptr] <= wr_rec;
  end

endmodule

/* rtl/rsfd_back.sv */
module rsfd_back import rsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         yaw_deadband_we,
  input  logic [9:0]   yaw_deadband_wdata,
  input  frame_rec_t   head,
  input  q_status_t    qs,
  output logic         pop,
  input  logic         res_stall,
  output logic         res_valid,
  output logic [1:0]   status,
  output logic [3:0]   wheel_fault_mask,
  output logic [3:0]   quantity,
  output logic [31:0]  value,
  output logic         last
);

  logic [9:0]         deadband;
  logic [3:0]         idx;
  logic signed [15:0] prev_yaw;
  logic               yaw_seen;
  logic signed [31:0] yaw_total;
  logic signed [16:0] yaw_delta;
  logic               yaw_hit;

  logic               load, good, final_q;
  logic [SLOT_W-1:0]  le_lo, be_hi;
  logic signed [15:0] yaw_now;
  logic signed [16:0] d_now, mag_now;
  logic signed [32:0] sum_next;
  logic signed [31:0] total_next;
  logic [31:0]        val_sel;

  assign load    = !qs.empty && (!res_valid || !res_stall);
  assign good    = (head.kind == ST_GOOD);
  assign final_q = (idx == Q_TOTAL);
  assign pop     = load && (!good || final_q);

  assign le_lo   = SLOT_W'({idx, 1'b0} - 5'd3);
  assign be_hi   = SLOT_W'({idx, 1'b0} - 5'd4);

  assign yaw_now = $signed({head.bytes[SL_YAW], head.bytes[SL_YAW + 1]});
  assign d_now   = yaw_seen ? (17'(yaw_now) - 17'(prev_yaw)) : '0;
  assign mag_now = d_now[16] ? -d_now : d_now;

  always_comb begin
    sum_next = 33'(yaw_total) + (yaw_hit ? 33'(yaw_delta) : 33'sd0);
    // clamp to the 32-bit range on overflow
    if (sum_next[32] != sum_next[31])
      total_next = sum_next[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else
      total_next = sum_next[31:0];
  end

  always_comb begin
    case (idx) inside
      [Q_VEL0:Q_VEL2]: val_sel = 32'($signed(head.bytes[SLOT_W'(idx)] ^ 8'h80));
      [Q_ACC0:Q_GYR2]: val_sel = {16'd0, head.bytes[le_lo + 1'b1], head.bytes[le_lo]}
                                 - LE16_OFFSET;
      Q_BATT:          val_sel = {24'd0, head.bytes[SL_BATT]};
      Q_BKP:           val_sel = (head.bytes[SL_BKP_FLAG][7:4] == BKP_TAG)
                                 ? {24'd0, head.bytes[SL_BKP]} : 32'd0;
      [Q_ROLL:Q_YAW]:  val_sel = 32'($signed({head.bytes[be_hi], head.bytes[be_hi + 1'b1]}));
      default:         val_sel = total_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband  <= 10'd10;
      idx       <= '0;
      res_valid <= 1'b0;
      prev_yaw  <= '0;
      yaw_seen  <= 1'b0;
      yaw_total <= '0;
    end else begin
      if (yaw_deadband_we) deadband <= yaw_deadband_wdata;
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (load && good) begin
        idx <= final_q ? '0 : idx + 1'b1;
        if (idx == Q_YAW) begin
          prev_yaw  <= yaw_now;
          yaw_seen  <= 1'b1;
          yaw_delta <= d_now;
          yaw_hit   <= (mag_now >= 17'(deadband));
        end
        if (final_q) yaw_total <= total_next;
      end
    end
    if (load) begin
      if (good) begin
        status           <= ST_GOOD;
        wheel_fault_mask <= '0;
        quantity         <= idx;
        value            <= val_sel;
        last             <= final_q;
      end else begin
        status           <= head.kind;
        wheel_fault_mask <= (head.kind == ST_STALL) ? head.mask : 4'd0;
        quantity         <= '0;
        value            <= '0;
        last             <= 1'b1;
      end
    end
  end

endmodule

/* rtl/robot_status_frame_decoder_core.sv */
// Path from a frame's last byte to its first result: queue entry, then output register.
// Throughput: one byte per cycle in unless stalled; one result per cycle out unless
// res_stall holds (15 for a good frame). A two-entry frame queue parts byte intake from
// result output; intake holds only on a frame's last byte when both entries are taken.
// Reset (rst, synchronous): hunt restarts, queue empties, yaw state clears,
// deadband returns to 10.
module robot_status_frame_decoder_core import rsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        yaw_deadband_we,
  input  logic [9:0]  yaw_deadband_wdata,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [3:0]  wheel_fault_mask,
  output logic [3:0]  quantity,
  output logic [31:0] value,
  output logic        last
);

  q_status_t  qs;
  frame_rec_t fr_rec, head;
  logic       push, pop, take;

  assign take = rx_valid && !rx_stall;

  rsfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .qs      (qs),
    .hold    (rx_stall),
    .push    (push),
    .rec     (fr_rec)
  );

  rsfd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (fr_rec),
    .pop    (pop),
    .head   (head),
    .qs     (qs)
  );

  rsfd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .yaw_deadband_we    (yaw_deadband_we),
    .yaw_deadband_wdata (yaw_deadband_wdata),
    .head               (head),
    .qs                 (qs),
    .pop                (pop),
    .res_stall          (res_stall),
    .res_valid          (res_valid),
    .status             (status),
    .wheel_fault_mask   (wheel_fault_mask),
    .quantity           (quantity),
    .value              (value),
    .last               (last)
  );

endmodule

/* rtl/rsfd_checker.sv */
module rsfd_checker import rsfd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic [1:0]  status,
  input logic [3:0]  wheel_fault_mask,
  input logic [3:0]  quantity,
  input logic [31:0] value,
  input logic        last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(value) && $stable(quantity)
                               && $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_GOOD |-> last && quantity == 4'd0 && value == 32'd0)
    else $error("stall or error result malformed");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_GOOD |-> last == (quantity == Q_TOTAL))
    else $error("good frame ends at wrong quantity");

  a_mask: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_STALL |-> wheel_fault_mask == 4'd0)
    else $error("wheel mask outside stall result");

endmodule

bind robot_status_frame_decoder_core rsfd_checker u_rsfd_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res_valid),
  .res_stall        (res_stall),
  .status           (status),
  .wheel_fault_mask (wheel_fault_mask),
  .quantity         (quantity),
  .value            (value),
  .last             (last)
);
